// File: hdl/xhc_pkg.sv
// ----------------------------------------------------------------------------
// xhc_pkg: shared types and constants of the XOR hex cipher block
// Command and status codes, queue entry layout, back-end states and the
// hex digit decoder used by the front end.
// ----------------------------------------------------------------------------
package xhc_pkg;

  // Command codes on cmd
  localparam logic [1:0] CMD_ENCODE = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_CRACK  = 2'd2;

  // Status codes on status
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NONPRINT = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Character and crack constants
  localparam logic [7:0] SPACE_CODE = 8'd32;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [6:0] HIST_MAX   = 7'd127;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] UPPER_BIAS = 8'd55;  // 'A' - 10
  localparam logic [7:0] LOWER_BIAS = 8'd87;  // 'a' - 10

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef enum logic {
    KIND_EMIT,
    KIND_CRACK
  } xhc_kind_t;

  typedef struct packed {
    xhc_kind_t  kind;
    logic [7:0] data;
    logic       store;
    logic       finish;
  } xhc_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIST_UPD,
    ST_FINISH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } xhc_state_t;

  // Value of one hex-style character: digits, then letters of either case
  function automatic logic [7:0] digit_of(input logic [7:0] ch);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (ch >= CHAR_0 && ch <= CHAR_9) begin
        d = ch - CHAR_0;
      end else if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
        d = ch - UPPER_BIAS;
      end else if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
        d = ch - LOWER_BIAS;
      end
      return d;
    end
  endfunction

endpackage

// File: hdl/xhc_ram.sv
// ----------------------------------------------------------------------------
// xhc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, no reset of contents.
// ----------------------------------------------------------------------------
module xhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/xhc_queue.sv
// ----------------------------------------------------------------------------
// xhc_queue: short item queue between front and back end
// Register FIFO of decoded work entries; full holds the front end off.
// ----------------------------------------------------------------------------
module xhc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  xhc_pkg::xhc_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output xhc_pkg::xhc_entry_t head
);

  xhc_pkg::xhc_entry_t               slots [0:xhc_pkg::QUEUE_DEPTH-1];
  logic [xhc_pkg::QUEUE_AW-1:0]      wptr;
  logic [xhc_pkg::QUEUE_AW-1:0]      rptr;
  logic [xhc_pkg::QUEUE_CW-1:0]      count;

  assign full      = (count == xhc_pkg::QUEUE_CW'(xhc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/xhc_front.sv
// ----------------------------------------------------------------------------
// xhc_front: item intake and classification
// Accepts items, packs hex character pairs, applies the key for encode and
// decode, and pushes one work entry per item that needs back-end work.
// ----------------------------------------------------------------------------
module xhc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd,
  input  logic [7:0]         in_char,
  input  logic               end_of_message,
  input  logic [7:0]         cipher_key,
  input  logic               q_full,
  output logic               push,
  output xhc_pkg::xhc_entry_t push_entry
);

  logic       char_parity;
  logic       char_parity_next;
  logic [7:0] nibble_acc;
  logic [7:0] nibble_acc_next;
  logic [7:0] acc_new;
  logic       accept;
  logic       pair_done;

  assign accept    = start & ~q_full;
  assign acc_new   = {nibble_acc[3:0], 4'h0} + xhc_pkg::digit_of(in_char);
  assign pair_done = char_parity;

  // Classify the item and form the queue entry
  always_comb begin
    char_parity_next  = char_parity;
    nibble_acc_next   = nibble_acc;
    push              = 1'b0;
    push_entry.kind   = xhc_pkg::KIND_EMIT;
    push_entry.data   = in_char ^ cipher_key;
    push_entry.store  = 1'b0;
    push_entry.finish = 1'b0;
    case (cmd)
      xhc_pkg::CMD_ENCODE: begin
        push = accept;
      end
      xhc_pkg::CMD_DECODE: begin
        char_parity_next = ~char_parity;
        nibble_acc_next  = acc_new;
        push             = accept & pair_done;
        push_entry.data  = acc_new ^ cipher_key;
      end
      xhc_pkg::CMD_CRACK: begin
        char_parity_next  = ~char_parity;
        nibble_acc_next   = acc_new;
        push              = accept & (pair_done | end_of_message);
        push_entry.kind   = xhc_pkg::KIND_CRACK;
        push_entry.data   = acc_new;
        push_entry.store  = pair_done;
        push_entry.finish = end_of_message;
      end
      default: begin
        push = 1'b0;
      end
    endcase
    // Drop any unpaired character at the end of a message
    if (end_of_message && (cmd == xhc_pkg::CMD_ENCODE || cmd == xhc_pkg::CMD_DECODE ||
                           cmd == xhc_pkg::CMD_CRACK)) begin
      char_parity_next = 1'b0;
      nibble_acc_next  = 8'd0;
    end
  end

  // Hold pair state; update only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      char_parity <= 1'b0;
      nibble_acc  <= 8'd0;
    end else if (accept) begin
      char_parity <= char_parity_next;
      nibble_acc  <= nibble_acc_next;
    end
  end

endmodule

// File: hdl/xhc_back.sv
// ----------------------------------------------------------------------------
// xhc_back: work execution and result generation
// Emits encode and decode results, stores crack bytes with a histogram and a
// running most-frequent byte, and runs the check and emit sweeps at the end.
// ----------------------------------------------------------------------------
module xhc_back #(
  parameter int MAX_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  xhc_pkg::xhc_entry_t q_head,
  output logic               q_pop,
  output logic               strobe,
  output logic [7:0]         out_byte,
  output logic [7:0]         popular_byte,
  output logic [1:0]         status,
  output logic               last_result
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW = $clog2(MAX_BYTES + 1);

  xhc_pkg::xhc_state_t state;
  xhc_pkg::xhc_state_t state_next;

  logic [7:0]    cur_byte;
  logic          cur_finish;
  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic          overflow_flag;
  logic          overflow_flag_next;
  logic [7:0]    best_byte;
  logic [7:0]    best_byte_next;
  logic [6:0]    best_cnt;
  logic [6:0]    best_cnt_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_next;
  logic [CW-1:0] idx_inc;
  logic [255:0]  hist_valid;
  logic          hist_valid_q;
  logic          clear_all;
  logic          set_valid;

  logic          store_we;
  logic [AW-1:0] store_raddr;
  logic [7:0]    store_q;
  logic          hist_we;
  logic [7:0]    hist_raddr;
  logic [6:0]    hist_q;
  logic [6:0]    hist_cnt;
  logic [6:0]    hist_inc;
  logic [7:0]    plain;
  logic [7:0]    crack_key;

  logic          emit;
  logic [7:0]    emit_byte;
  logic [7:0]    emit_pop;
  logic [1:0]    emit_status;
  logic          emit_last;

  // Byte store and histogram memories
  xhc_ram #(.WIDTH(8), .DEPTH(MAX_BYTES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (q_head.data),
    .raddr (store_raddr),
    .rdata (store_q)
  );

  xhc_ram #(.WIDTH(7), .DEPTH(256), .AW(8)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (cur_byte),
    .wdata (hist_inc),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  assign hist_raddr  = q_head.data;
  assign store_raddr = idx[AW-1:0];
  assign hist_cnt    = hist_valid_q ? hist_q : 7'd0;
  assign hist_inc    = (hist_cnt == xhc_pkg::HIST_MAX) ? hist_cnt : hist_cnt + 7'd1;
  assign crack_key   = best_byte ^ xhc_pkg::SPACE_CODE;
  assign plain       = store_q ^ crack_key;
  assign idx_inc     = idx + CW'(1);

  // Next state, memory controls and result selection
  always_comb begin
    state_next         = state;
    q_pop              = 1'b0;
    store_we           = 1'b0;
    hist_we            = 1'b0;
    set_valid          = 1'b0;
    clear_all          = 1'b0;
    byte_count_next    = byte_count;
    overflow_flag_next = overflow_flag;
    best_byte_next     = best_byte;
    best_cnt_next      = best_cnt;
    idx_next           = idx;
    emit               = 1'b0;
    emit_byte          = 8'd0;
    emit_pop           = best_byte;
    emit_status        = xhc_pkg::STATUS_OK;
    emit_last          = 1'b1;
    case (state)
      xhc_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == xhc_pkg::KIND_EMIT) begin
            emit      = 1'b1;
            emit_byte = q_head.data;
            emit_pop  = 8'd0;
          end else if (q_head.store && byte_count < CW'(MAX_BYTES)) begin
            store_we   = 1'b1;
            state_next = xhc_pkg::ST_HIST_UPD;
          end else begin
            if (q_head.store) begin
              overflow_flag_next = 1'b1;
            end
            state_next = q_head.finish ? xhc_pkg::ST_FINISH : xhc_pkg::ST_IDLE;
          end
        end
      end
      xhc_pkg::ST_HIST_UPD: begin
        hist_we         = 1'b1;
        set_valid       = 1'b1;
        byte_count_next = byte_count + CW'(1);
        if (hist_inc > best_cnt || (hist_inc == best_cnt && cur_byte < best_byte)) begin
          best_byte_next = cur_byte;
          best_cnt_next  = hist_inc;
        end
        state_next = cur_finish ? xhc_pkg::ST_FINISH : xhc_pkg::ST_IDLE;
      end
      xhc_pkg::ST_FINISH: begin
        if (overflow_flag) begin
          emit        = 1'b1;
          emit_status = xhc_pkg::STATUS_OVERFLOW;
          clear_all   = 1'b1;
          state_next  = xhc_pkg::ST_IDLE;
        end else if (byte_count == '0) begin
          clear_all  = 1'b1;
          state_next = xhc_pkg::ST_IDLE;
        end else begin
          idx_next   = '0;
          state_next = xhc_pkg::ST_SCAN_RD;
        end
      end
      xhc_pkg::ST_SCAN_RD: begin
        state_next = xhc_pkg::ST_SCAN_CHK;
      end
      xhc_pkg::ST_SCAN_CHK: begin
        if (plain < xhc_pkg::PRINT_LOW || plain > xhc_pkg::PRINT_HIGH) begin
          emit        = 1'b1;
          emit_status = xhc_pkg::STATUS_NONPRINT;
          clear_all   = 1'b1;
          state_next  = xhc_pkg::ST_IDLE;
        end else if (idx_inc == byte_count) begin
          idx_next   = '0;
          state_next = xhc_pkg::ST_EMIT_RD;
        end else begin
          idx_next   = idx_inc;
          state_next = xhc_pkg::ST_SCAN_RD;
        end
      end
      xhc_pkg::ST_EMIT_RD: begin
        state_next = xhc_pkg::ST_EMIT_OUT;
      end
      xhc_pkg::ST_EMIT_OUT: begin
        emit      = 1'b1;
        emit_byte = plain;
        emit_last = (idx_inc == byte_count);
        if (idx_inc == byte_count) begin
          clear_all  = 1'b1;
          state_next = xhc_pkg::ST_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = xhc_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = xhc_pkg::ST_IDLE;
      end
    endcase
    // Drop all crack state at the end of a message
    if (clear_all) begin
      byte_count_next    = '0;
      overflow_flag_next = 1'b0;
      best_byte_next     = 8'd0;
      best_cnt_next      = 7'd0;
    end
  end

  // State and crack bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= xhc_pkg::ST_IDLE;
      byte_count    <= '0;
      overflow_flag <= 1'b0;
      best_byte     <= 8'd0;
      best_cnt      <= 7'd0;
      idx           <= '0;
      hist_valid    <= '0;
      strobe        <= 1'b0;
    end else begin
      state         <= state_next;
      byte_count    <= byte_count_next;
      overflow_flag <= overflow_flag_next;
      best_byte     <= best_byte_next;
      best_cnt      <= best_cnt_next;
      idx           <= idx_next;
      strobe        <= emit;
      if (clear_all) begin
        hist_valid <= '0;
      end else if (set_valid) begin
        hist_valid[cur_byte] <= 1'b1;
      end
    end
  end

  // Latch the popped entry and the result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_byte   <= q_head.data;
      cur_finish <= q_head.finish;
    end
    hist_valid_q <= hist_valid[hist_raddr];
    if (emit) begin
      out_byte     <= emit_byte;
      popular_byte <= emit_pop;
      status       <= emit_status;
      last_result  <= emit_last;
    end
  end

endmodule

// File: hdl/xor_hex_cipher_with_crack.sv
// ----------------------------------------------------------------------------
// xor_hex_cipher_with_crack: single-byte XOR cipher with hex decode and crack
// Encode, hex decode and frequency crack of single-byte XOR messages.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/busy: an item is taken at a clock edge with start
//   high and busy low. cmd selects encode, hex decode or crack; cmd 3 is
//   ignored. The key is written through cfg_valid/cfg_ready/cfg_data; the
//   user must write it only while the block is idle, which the block itself
//   does not enforce; cfg_ready is always high. Results appear for one cycle
//   with strobe high; the receiver cannot stall. The intake takes one item per
//   cycle, while busy is low, into a four-entry queue; busy is high while that
//   queue is full. In the back end a stored crack byte passes the idle and the
//   histogram read-modify-write states, other crack items the idle state only.
//   A crack end passes the finish state, then a printable check sweep and an
//   emit sweep over the stored bytes, each alternating a read state and a
//   check or emit state as set by the registered read of the byte store.
//   Reset clears the key, the pair state, the queue and all crack state;
//   histogram entries are marked empty at once by valid bits.
// ----------------------------------------------------------------------------
module xor_hex_cipher_with_crack #(
  parameter int MAX_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] in_char,
  input  logic       end_of_message,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       strobe,
  output logic [7:0] out_byte,
  output logic [7:0] popular_byte,
  output logic [1:0] status,
  output logic       last_result
);

  logic               [7:0] cipher_key;
  logic                     q_full;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_not_empty;
  xhc_pkg::xhc_entry_t      q_push_entry;
  xhc_pkg::xhc_entry_t      q_head;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  // Hold the key register
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      cipher_key <= cfg_data;
    end
  end

  xhc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .cmd            (cmd),
    .in_char        (in_char),
    .end_of_message (end_of_message),
    .cipher_key     (cipher_key),
    .q_full         (q_full),
    .push           (q_push),
    .push_entry     (q_push_entry)
  );

  xhc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  xhc_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .strobe       (strobe),
    .out_byte     (out_byte),
    .popular_byte (popular_byte),
    .status       (status),
    .last_result  (last_result)
  );

endmodule
